// ===== rtl/core/bbd_pkg.sv =====
package bbd_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W      = 18;
  localparam int unsigned NB_W       = 16;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned FH_W       = 15;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ROW_W      = 14;
  localparam int unsigned MAX_HEIGHT = 16384;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Reset values of the registers
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(4096);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1);

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } bbd_chan_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CFA_PATTERN  = 2'd2
  } bbd_cfg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_FLUSH  = 1'b1
  } bbd_kind_e;

  // Color at each site of the 2x2 tile, index {row lsb, col lsb}, per pattern
  localparam logic [3:0][3:0][1:0] CFA_TABLE = '{
    '{2'd1, 2'd0, 2'd2, 2'd1},   // GBRG
    '{2'd1, 2'd2, 2'd0, 2'd1},   // GRBG
    '{2'd0, 2'd1, 2'd1, 2'd2},   // BGGR
    '{2'd2, 2'd1, 2'd1, 2'd0}    // RGGB
  };

  // 3x3 neighborhood, [row][col]
  typedef logic [2:0][2:0][NB_W-1:0] bbd_nb_t;

  // Control of one item on its way to the window stage
  typedef struct packed {
    logic write;      // write the line memory back
    logic bottom;     // new bottom sample repeats the middle row
    logic valid;      // item produces pixels
    logic last;       // last column of the row
    logic final_px;   // last column of the frame
    logic prow_zero;  // pixel row is the top row
    logic prow_lsb;
    logic col_zero;
    logic col_one;
    logic col_lsb;
  } bbd_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
    logic             run_last;
  } bbd_pix_t;

  typedef struct packed {
    logic [1:0] n;
    bbd_pix_t   pix0;
    bbd_pix_t   pix1;
  } bbd_push_t;

  // Gather the neighborhood of one pixel from the window
  function automatic bbd_nb_t bbd_pick(bbd_nb_t w, logic top_dup,
                                       logic [1:0] lc, logic [1:0] cc, logic [1:0] rc);
    bbd_nb_t    v;
    logic [1:0] r0;
    r0 = top_dup ? 2'd1 : 2'd0;
    v[0][0] = w[r0][lc];
    v[0][1] = w[r0][cc];
    v[0][2] = w[r0][rc];
    v[1][0] = w[1][lc];
    v[1][1] = w[1][cc];
    v[1][2] = w[1][rc];
    v[2][0] = w[2][lc];
    v[2][1] = w[2][cc];
    v[2][2] = w[2][rc];
    return v;
  endfunction

  // Bilinear interpolation of one site, values times four
  function automatic bbd_pix_t bbd_pixel(bbd_nb_t v, logic [1:0] pat, logic prow_lsb,
                                         logic pc_lsb, logic fe, logic rl);
    bbd_pix_t        p;
    bbd_chan_e       ch;
    bbd_chan_e       up;
    logic [NB_W-1:0] ctr;
    logic [NB_W:0]   vert;
    logic [NB_W:0]   horz;
    logic [PIX_W-1:0] edges;
    logic [PIX_W-1:0] diag;
    ch    = bbd_chan_e'(CFA_TABLE[pat][{prow_lsb, pc_lsb}]);
    up    = bbd_chan_e'(CFA_TABLE[pat][{~prow_lsb, pc_lsb}]);
    ctr   = v[1][1];
    vert  = (NB_W+1)'(v[0][1]) + (NB_W+1)'(v[2][1]);
    horz  = (NB_W+1)'(v[1][0]) + (NB_W+1)'(v[1][2]);
    edges = PIX_W'(vert) + PIX_W'(horz);
    diag  = PIX_W'(v[0][0]) + PIX_W'(v[0][2]) + PIX_W'(v[2][0]) + PIX_W'(v[2][2]);
    p.frame_end = fe;
    p.run_last  = rl;
    unique case (ch)
      CH_RED: begin
        p.red   = {ctr, 2'b00};
        p.green = edges;
        p.blue  = diag;
      end
      CH_BLUE: begin
        p.blue  = {ctr, 2'b00};
        p.green = edges;
        p.red   = diag;
      end
      default: begin
        p.green = {ctr, 2'b00};
        if (up == CH_RED) begin
          p.red  = {vert, 1'b0};
          p.blue = {horz, 1'b0};
        end else begin
          p.blue = {vert, 1'b0};
          p.red  = {horz, 1'b0};
        end
      end
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/bbd_in_if.sv =====
interface bbd_in_if;
  import bbd_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output kind, output raw_sample, input ready);
  modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

// ===== rtl/core/bbd_out_if.sv =====
interface bbd_out_if;
  import bbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             frame_end;
  logic             run_last;

  modport source (output valid, output red, output green, output blue,
                  output frame_end, output run_last, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input frame_end, input run_last, output ready);
endinterface

// ===== rtl/core/bayer_bilinear_demosaic.sv =====
// Channel   Dir  Handshake      Word
// in_if     in   valid/ready    kind, raw_sample
// out_if    out  valid/ready    red, green, blue, frame_end, run_last
// cfg       in   cfg_we_i       cfg_index_i, cfg_data_i
//
// One input word per cycle while the output queue has room; a word in the
// last column of a row can yield two pixels, which leave one at a time
// through the single output port. A pixel passes the line memory read, then
// the window stage, into a four-entry output queue.
// Reset clears counters, window and queue; the line memory is not cleared.
// A stalled output fills the queue until it lacks room for two pixels, then holds the window stage and input.
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bbd_in_if.sink               in_if,
  bbd_out_if.source            out_if
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned EW  = 15;
  localparam int unsigned SBW = SAMPLE_BITS;

  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [1:0]       cfa_pattern_q;
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             drain_q, drain_d;
  logic [EW-1:0]    eff_w;
  logic [FH_W-1:0]  eff_h;
  logic             last;
  logic             row_end;
  logic             is_flush;
  logic             act;
  logic             in_fire;
  logic             load;
  bbd_item_t        item;
  logic             take;
  logic             space;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [2*SBW-1:0] mem_wdata;
  logic [2*SBW-1:0] mem_rdata;
  bbd_push_t        push;
  bbd_pix_t         head;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      cfa_pattern_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (bbd_cfg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        CFG_CFA_PATTERN:  cfa_pattern_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to its usable range
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = EW'(1);
    end else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = FH_W'(1);
    end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height_q;
    end
  end

  // Decode the incoming word
  always_comb begin
    is_flush = (bbd_kind_e'(in_if.kind) == KIND_FLUSH);
    act      = is_flush ? drain_q : !drain_q;
    in_fire  = in_if.valid && take;
    load     = in_fire && act;
    last     = (EW'(col_q) + EW'(1)) >= eff_w;
    row_end  = (FH_W'(row_q) + FH_W'(1)) >= eff_h;

    item.write     = !is_flush;
    item.bottom    = is_flush;
    item.valid     = is_flush || (row_q != '0);
    item.last      = last;
    item.final_px  = is_flush && last;
    item.prow_zero = is_flush ? (row_q == '0) : (row_q <= ROW_W'(1));
    item.prow_lsb  = is_flush ? row_q[0] : ~row_q[0];
    item.col_zero  = (col_q == '0);
    item.col_one   = (col_q == AW'(1));
    item.col_lsb   = col_q[0];
  end

  // Advance column, row and drain state
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (load) begin
      if (!last) begin
        col_d = col_q + AW'(1);
      end else if (is_flush) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = '0;
        if (row_end) begin
          drain_d = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  assign in_if.ready = take;

  bbd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * SBW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (load),
    .raddr_i (col_q),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bbd_window #(
    .AW          (AW),
    .SAMPLE_BITS (SBW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .item_i    (item),
    .sample_i  (in_if.raw_sample[SBW-1:0]),
    .addr_i    (col_q),
    .rd_data_i (mem_rdata),
    .cfa_i     (cfa_pattern_q),
    .space_i   (space),
    .take_o    (take),
    .we_o      (mem_we),
    .waddr_o   (mem_waddr),
    .wdata_o   (mem_wdata),
    .push_o    (push)
  );

  bbd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .data_o  (head)
  );

  assign out_if.red       = head.red;
  assign out_if.green     = head.green;
  assign out_if.blue      = head.blue;
  assign out_if.frame_end = head.frame_end;
  assign out_if.run_last  = head.run_last;

endmodule

// ===== rtl/core/bbd_line_mem.sv =====
module bbd_line_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // Remember a read that hits the entry written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/core/bbd_window.sv =====
module bbd_window
  import bbd_pkg::*;
#(
  parameter int unsigned AW          = 12,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  bbd_item_t                item_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [AW-1:0]            addr_i,
  input  logic [2*SAMPLE_BITS-1:0] rd_data_i,
  input  logic [1:0]               cfa_i,
  input  logic                     space_i,
  output logic                     take_o,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic [2*SAMPLE_BITS-1:0] wdata_o,
  output bbd_push_t                push_o
);

  logic                   s1_q, s1_d;
  bbd_item_t              item_q;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [AW-1:0]          addr_q;
  logic [SAMPLE_BITS-1:0] win_q [3][3];
  logic [SAMPLE_BITS-1:0] win_d [3][3];
  logic [SAMPLE_BITS-1:0] nc    [3];
  logic                   fire;
  bbd_nb_t                nb;
  bbd_nb_t                va;
  bbd_nb_t                vb;
  bbd_pix_t               pa;
  bbd_pix_t               pb;
  logic                   a_v;
  logic                   b_v;

  assign fire   = s1_q && space_i;
  assign take_o = !s1_q || space_i;
  assign s1_d   = load_i ? 1'b1 : (fire ? 1'b0 : s1_q);

  // New column: top from two rows up, middle from the row above, bottom new or, on a flush, the middle again
  assign nc[0] = rd_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign nc[1] = rd_data_i[SAMPLE_BITS-1:0];
  assign nc[2] = item_q.bottom ? rd_data_i[SAMPLE_BITS-1:0] : samp_q;

  // Shift the window by one column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      win_d[r][2] = nc[r];
      for (int c = 0; c < 3; c++) begin
        nb[r][c] = NB_W'(win_d[r][c]);
      end
    end
  end

  // Pixels completed by this column
  always_comb begin
    va  = bbd_pick(nb, item_q.prow_zero, item_q.col_one ? 2'd1 : 2'd0, 2'd1, 2'd2);
    vb  = bbd_pick(nb, item_q.prow_zero, item_q.col_zero ? 2'd2 : 2'd1, 2'd2, 2'd2);
    pa  = bbd_pixel(va, cfa_i, item_q.prow_lsb, ~item_q.col_lsb, 1'b0, ~item_q.last);
    pb  = bbd_pixel(vb, cfa_i, item_q.prow_lsb, item_q.col_lsb, item_q.final_px, 1'b1);
    a_v = item_q.valid && !item_q.col_zero;
    b_v = item_q.valid && item_q.last;
    push_o.pix0 = a_v ? pa : pb;
    push_o.pix1 = pb;
    if (!fire) begin
      push_o.n = 2'd0;
    end else begin
      push_o.n = 2'(a_v) + 2'(b_v);
    end
  end

  // Write the rows back shifted by one
  assign we_o    = fire && item_q.write;
  assign waddr_o = addr_q;
  assign wdata_o = {rd_data_i[SAMPLE_BITS-1:0], samp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      s1_q <= s1_d;
      if (fire) begin
        win_q <= win_d;
      end
    end
  end

  // Hold the item while it waits for room downstream
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
      samp_q <= sample_i;
      addr_q <= addr_i;
    end
  end

endmodule

// ===== rtl/core/bbd_out_fifo.sv =====
module bbd_out_fifo
  import bbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bbd_push_t push_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output bbd_pix_t  data_o
);

  bbd_pix_t              ent_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign space_o = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q + FIFO_PTR_W'(push_i.n);
    rptr_d = rptr_q + FIFO_PTR_W'(pop);
    cnt_d  = cnt_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store one or two words per push
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      ent_q[wptr_q] <= push_i.pix0;
    end
    if (push_i.n == 2'd2) begin
      ent_q[wptr_q + FIFO_PTR_W'(1)] <= push_i.pix1;
    end
  end

endmodule

// ===== rtl/core/bbd_checker.sv =====
module bbd_checker
  import bbd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] out_red_i,
  input logic [PIX_W-1:0] out_green_i,
  input logic [PIX_W-1:0] out_blue_i,
  input logic             out_frame_end_i,
  input logic             out_run_last_i
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({out_red_i, out_green_i, out_blue_i, out_frame_end_i, out_run_last_i}))
    else $error("output word changed while stalled");

  // Frame end closes the run of its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_end_i |-> out_run_last_i)
    else $error("frame end without run end");

  // Input backpressure only comes from an output queue without room for two pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_red_i       (out_if.red),
  .out_green_i     (out_if.green),
  .out_blue_i      (out_if.blue),
  .out_frame_end_i (out_if.frame_end),
  .out_run_last_i  (out_if.run_last)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_TAIL  = 12;
  localparam int unsigned RANDOM_ITEMS = 540;

  typedef enum logic [1:0] {
    CFA_RGGB = 2'd0,
    CFA_BGGR = 2'd1,
    CFA_GRBG = 2'd2,
    CFA_GBRG = 2'd3
  } cfa_e;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_CHECKER,
    FILL_ONES
  } fill_e;

  // Demosaic scoreboard: mirrors line buffers, window and counters, and
  // queues the pixels each accepted word must produce.
  class pixel_scoreboard;
    localparam int unsigned LINE_DEPTH = 4096;
    localparam int unsigned ROW_LIMIT  = 16384;

    bit [15:0]   line_up [LINE_DEPTH];
    bit [15:0]   line_up2 [LINE_DEPTH];
    int unsigned win [3][3];
    int unsigned row_n;
    int unsigned col_n;
    int unsigned drain_n;
    bit          draining;
    logic [12:0] width_reg;
    logic [14:0] height_reg;
    logic [1:0]  pattern_reg;
    bbd_pix_t    expected_pixels [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      width_reg   = FRAME_WIDTH_RST;
      height_reg  = FRAME_HEIGHT_RST;
      pattern_reg = CFA_RGGB;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      return h;
    endfunction

    function void set_reg(bbd_cfg_e idx, int unsigned data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = data[12:0];
        CFG_FRAME_HEIGHT: height_reg = data[14:0];
        CFG_CFA_PATTERN:  pattern_reg = data[1:0];
        default: ;
      endcase
    endfunction

    function bbd_chan_e site_color(int unsigned row, int unsigned col);
      bbd_chan_e order [4];
      case (cfa_e'(pattern_reg))
        CFA_RGGB: order = '{CH_RED, CH_GREEN, CH_GREEN, CH_BLUE};
        CFA_BGGR: order = '{CH_BLUE, CH_GREEN, CH_GREEN, CH_RED};
        CFA_GRBG: order = '{CH_GREEN, CH_RED, CH_BLUE, CH_GREEN};
        default:  order = '{CH_GREEN, CH_BLUE, CH_RED, CH_GREEN};
      endcase
      return order[{row[0], col[0]}];
    endfunction

    // Interpolate one site from the window; lc/cc/rc pick window columns
    function bbd_pix_t make_pixel(int unsigned prow, int unsigned pc, int unsigned lc,
                                  int unsigned cc, int unsigned rc, bit fe, bit rl);
      int unsigned v [3][3];
      int unsigned sel [3];
      int unsigned rsel [3];
      int unsigned i, j;
      int unsigned ctr, vert, horz, edges, diag, r, g, b;
      bbd_chan_e   site;
      bbd_pix_t    p;
      rsel[0] = (prow == 0) ? 1 : 0;
      rsel[1] = 1;
      rsel[2] = 2;
      sel[0] = lc;
      sel[1] = cc;
      sel[2] = rc;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          v[i][j] = win[rsel[i]][sel[j]];
      ctr   = v[1][1];
      vert  = v[0][1] + v[2][1];
      horz  = v[1][0] + v[1][2];
      edges = vert + horz;
      diag  = v[0][0] + v[0][2] + v[2][0] + v[2][2];
      site  = site_color(prow, pc);
      if (site == CH_RED) begin
        r = 4 * ctr;
        g = edges;
        b = diag;
      end else if (site == CH_BLUE) begin
        b = 4 * ctr;
        g = edges;
        r = diag;
      end else begin
        g = 4 * ctr;
        // Vertical pair carries the color of the row above
        if (site_color(prow + 1, pc) == CH_RED) begin
          r = 2 * vert;
          b = 2 * horz;
        end else begin
          b = 2 * vert;
          r = 2 * horz;
        end
      end
      p.red       = PIX_W'(r);
      p.green     = PIX_W'(g);
      p.blue      = PIX_W'(b);
      p.frame_end = fe;
      p.run_last  = rl;
      return p;
    endfunction

    // Shift a new column into the window and queue the pixels it completes
    function void shift_in(int unsigned top, int unsigned mid, int unsigned bot,
                           int unsigned c, bit last, bit live, int unsigned prow, bit fin);
      int unsigned i;
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = bot;
      if (!live) return;
      if (c >= 1)
        expected_pixels.push_back(make_pixel(prow, c - 1, (c == 1) ? 1 : 0, 1, 2, 1'b0,
                                             !last));
      if (last)
        expected_pixels.push_back(make_pixel(prow, c, (c == 0) ? 2 : 1, 2, 2, fin, 1'b1));
    endfunction

    // Note one accepted input word
    function void note_word(bbd_kind_e kind, logic [RAW_W-1:0] raw);
      int unsigned w, h, c, top, mid;
      bit          last;
      w   = eff_width();
      h   = eff_height();
      top = 0;
      mid = 0;
      if (kind == KIND_SAMPLE) begin
        if (draining) return;
        c = col_n;
        if (c < LINE_DEPTH) begin
          top = line_up2[c];
          mid = line_up[c];
          line_up2[c] = mid[15:0];
          line_up[c]  = raw;
        end
        last = (c + 1 >= w);
        shift_in(top, mid, raw, c, last, row_n >= 1, (row_n >= 1) ? row_n - 1 : 0, 1'b0);
        if (last) begin
          col_n = 0;
          if (row_n + 1 >= h) begin
            draining = 1'b1;
            drain_n  = 0;
          end else begin
            row_n++;
          end
        end else begin
          col_n++;
        end
      end else begin
        if (!draining) return;
        c = drain_n;
        if (c < LINE_DEPTH) begin
          top = line_up2[c];
          mid = line_up[c];
        end
        last = (c + 1 >= w);
        shift_in(top, mid, mid, c, last, 1'b1, row_n, last);
        if (last) begin
          row_n    = 0;
          col_n    = 0;
          drain_n  = 0;
          draining = 1'b0;
        end else begin
          drain_n++;
        end
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 40)
        $display("pixel %0d: %s got 0x%0h want 0x%0h", checked, what, got, want);
    endtask

    // Check one accepted pixel against the oldest expectation
    task check_pixel(bbd_pix_t got);
      bbd_pix_t want;
      if (expected_pixels.size() == 0) begin
        report("unexpected pixel, red", got.red, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red != want.red) report("red", got.red, want.red);
        if (got.green != want.green) report("green", got.green, want.green);
        if (got.blue != want.blue) report("blue", got.blue, want.blue);
        if (got.frame_end != want.frame_end)
          report("frame_end", got.frame_end, want.frame_end);
        if (got.run_last != want.run_last) report("run_last", got.run_last, want.run_last);
      end
      checked++;
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bbd_in_if  in_if ();
  bbd_out_if out_if ();

  pixel_scoreboard sb = new();

  int unsigned cycle_count;
  int unsigned real_items;
  int unsigned burst_left;
  bit          tx_steady;
  bit          rx_steady;

  bayer_bilinear_demosaic u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Monitor: note accepted words, then check accepted pixels
  always @(posedge clk_i) begin
    bbd_pix_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_word(bbd_kind_e'(in_if.kind), in_if.raw_sample);
      if (out_if.valid && out_if.ready) begin
        got.red       = out_if.red;
        got.green     = out_if.green;
        got.blue      = out_if.blue;
        got.frame_end = out_if.frame_end;
        got.run_last  = out_if.run_last;
        sb.check_pixel(got);
      end
    end
  end

  // Receiver: alternate runs of ready and stall unless held steady
  initial begin
    bit          rx_on;
    int unsigned rx_left;
    rx_on        = 1'b0;
    rx_left      = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_steady) begin
        out_if.ready = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_on   = !rx_on;
          rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 8);
        end
        rx_left--;
        out_if.ready = rx_on;
      end
    end
  end

  // Drive one word; gaps fall between random bursts
  task automatic send_word(bbd_kind_e kind, logic [RAW_W-1:0] raw);
    int unsigned gap;
    if (!tx_steady && burst_left == 0) begin
      in_if.valid = 1'b0;
      gap = $urandom_range(0, 7);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left != 0) burst_left--;
    in_if.valid      = 1'b1;
    in_if.kind       = kind;
    in_if.raw_sample = raw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold input until every expected pixel has arrived and the pipe is empty
  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TAIL) @(negedge clk_i);
  endtask

  task automatic write_reg(bbd_cfg_e idx, int unsigned data);
    in_if.valid = 1'b0;
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = CFG_W'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(int unsigned width, int unsigned height, cfa_e pat);
    settle();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    write_reg(CFG_CFA_PATTERN, pat);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw(fill_e fill, int unsigned r, int unsigned c);
    if (fill == FILL_ONES) return '1;
    if (fill == FILL_CHECKER) return ((r + c) % 2 != 0) ? '1 : '0;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // Send rows of samples; noisy adds stray flushes that the block drops
  task automatic send_rows(int unsigned rows, fill_e fill, bit noisy);
    int unsigned r, c, w;
    w = sb.eff_width();
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < w; c++) begin
        if (noisy && $urandom_range(0, 40) == 0)
          send_word(KIND_FLUSH, RAW_W'($urandom));
        if (noisy && $urandom_range(0, 300) == 0)
          settle();
        send_word(KIND_SAMPLE, pick_raw(fill, r, c));
        real_items++;
      end
    end
  endtask

  // Drain the bottom row; noisy adds stray samples that the block drops
  task automatic drain_row(bit noisy);
    int unsigned c, w;
    w = sb.eff_width();
    for (c = 0; c < w; c++) begin
      if (noisy && $urandom_range(0, 10) == 0)
        send_word(KIND_SAMPLE, RAW_W'($urandom));
      send_word(KIND_FLUSH, RAW_W'($urandom));
      real_items++;
    end
    if (noisy && $urandom_range(0, 3) == 0)
      send_word(KIND_FLUSH, RAW_W'($urandom));
  endtask

  function automatic int unsigned pick_width();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll < 14) return $urandom_range(1, 8);
    if (roll < 19) return $urandom_range(9, 40);
    return $urandom_range(41, 150);
  endfunction

  initial begin
    int unsigned goal;
    bit          new_w, new_h, new_p;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_FRAME_WIDTH;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_SAMPLE;
    in_if.raw_sample = '0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    burst_left       = 0;
    real_items       = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: stray flush out of reset, then small frames of each pattern
    send_word(KIND_FLUSH, '1);
    write_all(3, 3, CFA_RGGB);
    send_rows(3, FILL_CHECKER, 1'b0);
    send_word(KIND_SAMPLE, '1);
    drain_row(1'b0);
    write_all(0, 0, CFA_BGGR);
    send_rows(1, FILL_ONES, 1'b0);
    drain_row(1'b0);
    write_all(2, 2, CFA_GRBG);
    send_rows(2, FILL_ONES, 1'b0);
    drain_row(1'b0);
    write_all(1, 3, CFA_GBRG);
    send_rows(3, FILL_CHECKER, 1'b0);
    drain_row(1'b0);

    // Tallest frame, cut short by lowering the height between rows
    write_all(5, 32767, CFA_BGGR);
    send_rows(4, FILL_RANDOM, 1'b1);
    settle();
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_rows(1, FILL_RANDOM, 1'b1);
    drain_row(1'b1);

    // Random frames
    goal = real_items + RANDOM_ITEMS;
    while (real_items < goal) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      new_w = ($urandom_range(0, 2) != 0);
      new_h = ($urandom_range(0, 2) != 0);
      new_p = ($urandom_range(0, 2) != 0);
      if (new_w || new_h || new_p) settle();
      if (new_w) write_reg(CFG_FRAME_WIDTH, pick_width());
      if (new_h) write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 6));
      if (new_p) write_reg(CFG_CFA_PATTERN, $urandom_range(0, 3));
      send_rows(sb.eff_height(), FILL_RANDOM, 1'b1);
      drain_row(1'b1);
    end

    settle();
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bbd_pkg.sv
rtl/core/bbd_in_if.sv
rtl/core/bbd_out_if.sv
rtl/core/bbd_line_mem.sv
rtl/core/bbd_window.sv
rtl/core/bbd_out_fifo.sv
rtl/core/bayer_bilinear_demosaic.sv
rtl/core/bbd_checker.sv
bench/testbench.sv
